[sv/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, widths and helpers for the barometric sensor compensation.
// ----------------------------------------------------------------------------
package bsc_pkg;

	localparam int CAL_W       = 16;
	localparam int RAW_W       = 24;
	localparam int TEMP_W      = 24;
	localparam int PRESS_W     = 32;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 56;
	localparam int CFG_IDX_W   = 3;

	// Calibration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CAL_SENS  = 3'd0,
		CAL_OFF   = 3'd1,
		CAL_TCS   = 3'd2,
		CAL_TCO   = 3'd3,
		CAL_TREF  = 3'd4,
		CAL_SLOPE = 3'd5
	} cal_idx_t;

	typedef struct packed {
		logic [CAL_W-1:0] sens;
		logic [CAL_W-1:0] off;
		logic [CAL_W-1:0] tcs;
		logic [CAL_W-1:0] tco;
		logic [CAL_W-1:0] tref;
		logic [CAL_W-1:0] slope;
	} cal_t;

	// Signed shift right by sh, rounding toward zero as C division does
	function automatic logic signed [65:0] trunc_shr(input logic signed [65:0] x,
			input int unsigned sh);
		logic signed [65:0] bias;
		bias = x[65] ? ((66'sd1 <<< sh) - 66'sd1) : 66'sd0;
		return (x + bias) >>> sh;
	endfunction

endpackage

[sv/baro_sensor_compensation.sv]
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Second-order temperature compensated pressure and temperature from raw
// 24-bit conversions, using six calibration words.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while m_tready stays high; each of the 11
// stages holds its own item and moves on as soon as the next stage is free,
// so bubbles collapse on a stall.
// The 41x24 pressure product is split into two 21/20-bit partial products.
// Reset clears all stage valid bits and sets the calibration words to zero.
// ----------------------------------------------------------------------------
module baro_sensor_compensation (
	input  logic                          clk,
	input  logic                          arst_n,
	// config
	input  logic                          cfg_wr_en,
	input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [bsc_pkg::CAL_W-1:0]     cfg_wdata,
	// input items
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bsc_pkg::IN_TDATA_W-1:0] s_tdata,  // raw_pressure[23:0], raw_temperature[47:24]
	// result items
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bsc_pkg::OUT_TDATA_W-1:0] m_tdata  // temperature_centi[23:0], pressure_centi[55:24]
);
	import bsc_pkg::*;

	localparam int NSTG = 11;

	cal_t cal;

	bsc_cal_regs u_cal (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cal       (cal)
	);

	// Stage valids and advance chain
	logic [NSTG:1] vld_q;
	logic [NSTG:1] adv;

	assign adv[NSTG] = !vld_q[NSTG] || m_tready;
	for (genvar k = 1; k < NSTG; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end

	assign s_tready = adv[1];
	assign m_tvalid = vld_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) vld_q[1] <= s_tvalid;
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	logic [RAW_W-1:0] raw_p;
	logic [RAW_W-1:0] raw_t;
	assign raw_p = s_tdata[RAW_W-1:0];
	assign raw_t = s_tdata[2*RAW_W-1:RAW_W];

	logic signed [16:0] slope_sx, tco_sx, tcs_sx;
	assign slope_sx = $signed({1'b0, cal.slope});
	assign tco_sx   = $signed({1'b0, cal.tco});
	assign tcs_sx   = $signed({1'b0, cal.tcs});

	// Stage 1: temperature difference to reference
	logic signed [24:0] diff_s1;
	logic [RAW_W-1:0]   praw_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			diff_s1 <= $signed({1'b0, raw_t}) - $signed({1'b0, cal.tref, 8'h00});
			praw_s1 <= raw_p;
		end
	end

	// Stage 2: first-order products
	logic signed [41:0] mslope_s2, mtco_s2, mtcs_s2;
	logic signed [49:0] mdd_s2;
	logic [RAW_W-1:0]   praw_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			mslope_s2 <= diff_s1 * slope_sx;
			mtco_s2   <= diff_s1 * tco_sx;
			mtcs_s2   <= diff_s1 * tcs_sx;
			mdd_s2    <= diff_s1 * diff_s1;
			praw_s2   <= praw_s1;
		end
	end

	// Stage 3: first-order temperature, offset and sensitivity
	logic signed [65:0] tq, oq, sq;
	assign tq = trunc_shr(66'(mslope_s2), 23);
	assign oq = trunc_shr(66'(mtco_s2), 7);
	assign sq = trunc_shr(66'(mtcs_s2), 8);

	logic signed [19:0] temp1_s3;
	logic signed [40:0] offs1_s3, sens1_s3;
	logic [17:0]        corrt_s3;
	logic [RAW_W-1:0]   praw_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			temp1_s3 <= $signed(tq[19:0]) + 20'sd2000;
			offs1_s3 <= $signed({9'h000, cal.off, 16'h0000}) + $signed(oq[40:0]);
			sens1_s3 <= $signed({10'h000, cal.sens, 15'h0000}) + $signed(sq[40:0]);
			corrt_s3 <= mdd_s2[48:31];
			praw_s3  <= praw_s2;
		end
	end

	// Stage 4: squares for the low-temperature corrections
	logic signed [19:0] below, cold;
	logic signed [39:0] sqb_full, sqc_full;
	assign below    = temp1_s3 - 20'sd2000;
	assign cold     = temp1_s3 + 20'sd1500;
	assign sqb_full = below * below;
	assign sqc_full = cold * cold;

	logic signed [19:0] temp1_s4;
	logic               warm_s4, cold_s4;
	logic [34:0]        sqb_s4, sqc_s4;
	logic signed [40:0] offs1_s4, sens1_s4;
	logic [17:0]        corrt_s4;
	logic [RAW_W-1:0]   praw_s4;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			temp1_s4 <= temp1_s3;
			warm_s4  <= temp1_s3 < 20'sd2000;
			cold_s4  <= temp1_s3 < -20'sd1500;
			sqb_s4   <= sqb_full[34:0];
			sqc_s4   <= sqc_full[34:0];
			offs1_s4 <= offs1_s3;
			sens1_s4 <= sens1_s3;
			corrt_s4 <= corrt_s3;
			praw_s4  <= praw_s3;
		end
	end

	// Stage 5: correction terms and final temperature
	logic [39:0] five_b, seven_c, eleven_c;
	logic [39:0] corr_off, corr_sens;
	assign five_b   = 40'(sqb_s4) * 40'd5;
	assign seven_c  = 40'(sqc_s4) * 40'd7;
	assign eleven_c = 40'(sqc_s4) * 40'd11;

	always_comb begin
		corr_off  = '0;
		corr_sens = '0;
		if (warm_s4) begin
			corr_off  = five_b >> 1;
			corr_sens = five_b >> 2;
		end
		if (cold_s4) begin
			corr_off  = corr_off + seven_c;
			corr_sens = corr_sens + (eleven_c >> 1);
		end
	end

	logic signed [19:0] temp_s5;
	logic [39:0]        corroff_s5, corrsens_s5;
	logic signed [40:0] offs1_s5, sens1_s5;
	logic [RAW_W-1:0]   praw_s5;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			temp_s5     <= warm_s4 ? temp1_s4 - $signed({2'b00, corrt_s4}) : temp1_s4;
			corroff_s5  <= corr_off;
			corrsens_s5 <= corr_sens;
			offs1_s5    <= offs1_s4;
			sens1_s5    <= sens1_s4;
			praw_s5     <= praw_s4;
		end
	end

	// Stage 6: final offset and sensitivity
	logic signed [19:0] temp_s6;
	logic signed [40:0] offs_s6, sens_s6;
	logic [RAW_W-1:0]   praw_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			temp_s6 <= temp_s5;
			offs_s6 <= offs1_s5 - $signed({1'b0, corroff_s5});
			sens_s6 <= sens1_s5 - $signed({1'b0, corrsens_s5});
			praw_s6 <= praw_s5;
		end
	end

	// Stage 7: raw pressure times sensitivity, two partial products
	logic [20:0]        sens_lo;
	logic signed [19:0] sens_hi;
	assign sens_lo = sens_s6[20:0];
	assign sens_hi = sens_s6[40:21];

	logic signed [19:0] temp_s7;
	logic signed [40:0] offs_s7;
	logic [44:0]        pplo_s7;
	logic signed [44:0] pphi_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			temp_s7 <= temp_s6;
			offs_s7 <= offs_s6;
			pplo_s7 <= 45'(praw_s6) * 45'(sens_lo);
			pphi_s7 <= $signed({1'b0, praw_s6}) * sens_hi;
		end
	end

	// Stage 8: combine partial products
	logic signed [19:0] temp_s8;
	logic signed [40:0] offs_s8;
	logic signed [65:0] prod_s8;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			temp_s8 <= temp_s7;
			offs_s8 <= offs_s7;
			prod_s8 <= (66'(pphi_s7) <<< 21) + $signed({21'h0, pplo_s7});
		end
	end

	// Stage 9: scale product down
	logic signed [65:0] pq;
	assign pq = trunc_shr(prod_s8, 21);

	logic signed [19:0] temp_s9;
	logic signed [40:0] offs_s9;
	logic signed [44:0] q_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			temp_s9 <= temp_s8;
			offs_s9 <= offs_s8;
			q_s9    <= pq[44:0];
		end
	end

	// Stage 10: subtract offset
	logic signed [19:0] temp_s10;
	logic signed [45:0] d_s10;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			temp_s10 <= temp_s9;
			d_s10    <= 46'(q_s9) - 46'(offs_s9);
		end
	end

	// Stage 11: final scaling, output register
	logic signed [65:0] pr;
	assign pr = trunc_shr(66'(d_s10), 15);

	logic signed [19:0]       temp_s11;
	logic [PRESS_W-1:0]       press_s11;

	always_ff @(posedge clk) begin
		if (adv[11]) begin
			temp_s11  <= temp_s10;
			press_s11 <= pr[PRESS_W-1:0];
		end
	end

	assign m_tdata = {press_s11, TEMP_W'(temp_s11)};

	// Assertions
	a_ready_follows_sink: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output side is ready");

	a_last_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NSTG-1] && adv[NSTG]) |=> m_tvalid)
		else $error("item lost entering output register");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[1])
		else $error("accepted item missing from first stage");

endmodule

[sv/bsc_cal_regs.sv]
// ----------------------------------------------------------------------------
// bsc_cal_regs
// Six factory calibration words, written through a plain write port.
// ----------------------------------------------------------------------------
module bsc_cal_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [bsc_pkg::CAL_W-1:0]   cfg_wdata,
	output bsc_pkg::cal_t               cal
);
	import bsc_pkg::*;

	cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cal_idx_t'(cfg_addr))
				CAL_SENS:  cal_q.sens  <= cfg_wdata;
				CAL_OFF:   cal_q.off   <= cfg_wdata;
				CAL_TCS:   cal_q.tcs   <= cfg_wdata;
				CAL_TCO:   cal_q.tco   <= cfg_wdata;
				CAL_TREF:  cal_q.tref  <= cfg_wdata;
				CAL_SLOPE: cal_q.slope <= cfg_wdata;
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	assign cal = cal_q;

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams raw pressure/temperature pairs through baro_sensor_compensation
// under several calibration sets, predicts each compensated reading with 64-bit
// integer math and compares it field by field as results leave the block.
// ----------------------------------------------------------------------------
module testbench;
	import bsc_pkg::*;

	localparam int CLK_PERIOD  = 20;
	localparam int PIPE_LAT    = 11;
	localparam int HOLD_AFTER  = 800;
	localparam int HOLD_CYCLES = 400;
	localparam int N_PHASES    = 6;
	localparam int PHASE_ITEMS = 275;
	localparam longint TIMEOUT_NS = 4_000_000;

	localparam logic [RAW_W-1:0] RAW_MAX = 24'hFF_FFFF;
	localparam logic [CFG_IDX_W-1:0] CAL_UNUSED_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CAL_UNUSED_B = 3'd7;
	// sens, off, tcs, tco, tref, slope as found on a typical part
	localparam cal_t TYP_CAL = {16'd40127, 16'd36924, 16'd23317, 16'd23282,
		16'd33464, 16'd28312};
	localparam int TYP_BASE = int'(TYP_CAL.tref) * 256;

	typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

	typedef struct {
		logic [TEMP_W-1:0]  temperature_centi;
		logic [PRESS_W-1:0] pressure_centi;
	} reading_t;

	class compensated_readings;
		cal_t     cal;
		reading_t awaited[$];
		int       mismatches;

		function new();
			cal = '0;
			mismatches = 0;
		endfunction

		function void set_cal(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] val);
			case (idx)
				CAL_SENS:  cal.sens  = val;
				CAL_OFF:   cal.off   = val;
				CAL_TCS:   cal.tcs   = val;
				CAL_TCO:   cal.tco   = val;
				CAL_TREF:  cal.tref  = val;
				CAL_SLOPE: cal.slope = val;
				default: ;
			endcase
		endfunction

		function reading_t compensate(logic [RAW_W-1:0] p, logic [RAW_W-1:0] t);
			longint p_raw, t_raw, c_sens, c_off, c_tcs, c_tco, c_tref, c_slope;
			longint diff, temp0, temp, offs, sens, below, cold, press;
			reading_t r;
			p_raw   = p;
			t_raw   = t;
			c_sens  = cal.sens;
			c_off   = cal.off;
			c_tcs   = cal.tcs;
			c_tco   = cal.tco;
			c_tref  = cal.tref;
			c_slope = cal.slope;
			diff  = t_raw - c_tref * 256;
			temp0 = 2000 + (diff * c_slope) / 64'sd8388608;
			offs  = c_off * 65536 + (c_tco * diff) / 128;
			sens  = c_sens * 32768 + (c_tcs * diff) / 256;
			temp  = temp0;
			// second-order correction below 20.00 degC, extra term below -15.00 degC
			if (temp0 < 2000) begin
				below = temp0 - 2000;
				temp  = temp - (diff * diff) / 64'sd2147483648;
				offs  = offs - (5 * below * below) / 2;
				sens  = sens - (5 * below * below) / 4;
				if (temp0 < -1500) begin
					cold = temp0 + 1500;
					offs = offs - 7 * cold * cold;
					sens = sens - (11 * cold * cold) / 2;
				end
			end
			press = ((p_raw * sens) / 64'sd2097152 - offs) / 64'sd32768;
			r.temperature_centi = temp[TEMP_W-1:0];
			r.pressure_centi    = press[PRESS_W-1:0];
			return r;
		endfunction

		function void note_raw(logic [RAW_W-1:0] p, logic [RAW_W-1:0] t);
			awaited.push_back(compensate(p, t));
		endfunction

		function void check_output(logic [OUT_TDATA_W-1:0] data);
			reading_t exp_r;
			if (awaited.size() == 0) begin
				$error("result with no reading awaited: tdata %h", data);
				mismatches++;
				return;
			end
			exp_r = awaited.pop_front();
			if (data[TEMP_W-1:0] !== exp_r.temperature_centi) begin
				$error("temperature_centi: expected %0d, got %0d",
					$signed(exp_r.temperature_centi), $signed(data[TEMP_W-1:0]));
				mismatches++;
			end
			if (data[TEMP_W+PRESS_W-1:TEMP_W] !== exp_r.pressure_centi) begin
				$error("pressure_centi: expected %0d, got %0d",
					$signed(exp_r.pressure_centi),
					$signed(data[TEMP_W+PRESS_W-1:TEMP_W]));
				mismatches++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_addr  = '0;
	logic [CAL_W-1:0]       cfg_wdata = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;  // raw_pressure[23:0], raw_temperature[47:24]
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // temperature_centi[23:0], pressure_centi[55:24]

	compensated_readings readings = new();
	cal_t cal_now = '0;
	int   results_seen = 0;
	int   burst_left = 0;
	bit   gappy = 1'b0;

	baro_sensor_compensation u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			readings.check_output(m_tdata);
			results_seen++;
		end
	end

	// result side: stall on changing patterns, with one long hold-off
	initial begin
		rx_mode_t    mode;
		int          left;
		int          cyc;
		logic [15:0] pat;
		bit          held;
		mode = RX_OPEN;
		left = 0;
		cyc  = 0;
		pat  = '1;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					left = $urandom_range(16, 96);
					pat  = 16'($urandom);
				end
				left--;
				cyc++;
				case (mode)
					RX_OPEN:    m_tready <= 1'b1;
					RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
					RX_PATTERN: m_tready <= pat[cyc % 16];
					default:    m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		readings.set_cal(idx, val);
	endtask

	task automatic load_cal(input cal_t c, input bit poke_unused);
		write_reg(CAL_SENS, c.sens);
		write_reg(CAL_OFF, c.off);
		write_reg(CAL_TCS, c.tcs);
		write_reg(CAL_TCO, c.tco);
		write_reg(CAL_TREF, c.tref);
		write_reg(CAL_SLOPE, c.slope);
		// indexes past the last register must leave the calibration alone
		if (poke_unused) begin
			write_reg(CAL_UNUSED_A, 16'hFFFF);
			write_reg(CAL_UNUSED_B, 16'hA5A5);
		end
		cfg_wr_en <= 1'b0;
		cal_now = c;
		@(posedge clk);
	endtask

	task automatic push_reading(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
		s_tdata  <= {t, p};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		readings.note_raw(p, t);
		if (gappy) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 15);
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
		end
	endtask

	// drop valid and hold off until every reading has come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (readings.pending() != 0) @(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	function automatic logic [CAL_W-1:0] pick_cal_word(input logic [CAL_W-1:0] typ,
			input int style);
		logic [CAL_W-1:0] w;
		case (style)
			0: w = typ + CAL_W'($urandom_range(0, 8191)) - CAL_W'(4096);
			1: w = CAL_W'($urandom);
			default: begin
				case ($urandom_range(0, 2))
					0: w = '0;
					1: w = '1;
					default: w = CAL_W'($urandom);
				endcase
			end
		endcase
		return w;
	endfunction

	function automatic cal_t random_cal();
		cal_t c;
		int   style;
		style   = $urandom_range(0, 2);
		c.sens  = pick_cal_word(TYP_CAL.sens, style);
		c.off   = pick_cal_word(TYP_CAL.off, style);
		c.tcs   = pick_cal_word(TYP_CAL.tcs, style);
		c.tco   = pick_cal_word(TYP_CAL.tco, style);
		c.tref  = pick_cal_word(TYP_CAL.tref, style);
		c.slope = pick_cal_word(TYP_CAL.slope, style);
		return c;
	endfunction

	function automatic logic [RAW_W-1:0] clamp_raw(input int v);
		if (v < 0)
			return '0;
		if (v > int'(RAW_MAX))
			return RAW_MAX;
		return v[RAW_W-1:0];
	endfunction

	// aim around the reference point so both correction ranges get hit
	function automatic logic [RAW_W-1:0] random_temperature(input logic [CAL_W-1:0] tref);
		int base;
		base = int'(tref) * 256;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return RAW_W'($urandom_range(0, int'(RAW_MAX)));
			4, 5, 6:    return clamp_raw(base + $urandom_range(0, 8191) - 4096);
			7, 8:       return clamp_raw(base - $urandom_range(0, 2_500_000));
			default:    return $urandom_range(0, 1) ? RAW_MAX : '0;
		endcase
	endfunction

	function automatic logic [RAW_W-1:0] random_pressure();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return RAW_W'($urandom_range(0, int'(RAW_MAX)));
			6, 7, 8:          return RAW_W'($urandom_range(5_000_000, 10_000_000));
			default:          return $urandom_range(0, 1) ? RAW_MAX : '0;
		endcase
	endfunction

	initial begin
		#(TIMEOUT_NS);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// calibration still at its reset value
		push_reading('0, '0);
		push_reading(RAW_MAX, RAW_MAX);
		wait_idle();

		// typical part: walk the 20.00 and -15.00 degC borders
		gappy = 1'b1;
		load_cal(TYP_CAL, 1'b0);
		push_reading(24'd9085466, 24'(TYP_BASE));
		push_reading(24'd9085466, 24'(TYP_BASE - 296));
		push_reading(24'd9085466, 24'(TYP_BASE - 297));
		push_reading(24'd9085466, 24'(TYP_BASE - 1037316));
		push_reading(24'd9085466, 24'(TYP_BASE - 1037317));
		push_reading(24'd6465444, 24'(TYP_BASE + 1000000));
		push_reading('0, '0);
		push_reading(RAW_MAX, RAW_MAX);
		push_reading(RAW_MAX, '0);
		push_reading('0, RAW_MAX);
		wait_idle();

		gappy = 1'b0;
		load_cal('1, 1'b0);
		push_reading(RAW_MAX, RAW_MAX);
		push_reading('0, '0);
		push_reading(RAW_MAX, '0);
		push_reading('0, RAW_MAX);
		push_reading(24'hAAAAAA, 24'h555555);
		wait_idle();

		load_cal('0, 1'b1);
		push_reading(RAW_MAX, RAW_MAX);
		push_reading(24'h555555, 24'hAAAAAA);
		wait_idle();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			load_cal(random_cal(), ph == 2);
			gappy = (ph % 3 != 0);
			burst_left = 0;
			repeat (PHASE_ITEMS)
				push_reading(random_pressure(), random_temperature(cal_now.tref));
			wait_idle();
		end

		repeat (PIPE_LAT * 2) @(posedge clk);
		if (readings.mismatches == 0 && readings.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[files.f]
sv/bsc_pkg.sv
sv/bsc_cal_regs.sv
sv/baro_sensor_compensation.sv
bench/testbench.sv
